// ===== sv/lpi_pkg.sv =====
// ----------------------------------------------------------------------------
// lpi_pkg
// Types and constants shared by the line / plane intersection block.
// ----------------------------------------------------------------------------
package lpi_pkg;

  localparam int unsigned QDepth  = 4;
  localparam int unsigned QPtrW   = $clog2(QDepth);
  localparam int unsigned QCntW   = $clog2(QDepth + 1);
  // Dividend is |dir| (33 bits) times |numerator| (64 bits).
  localparam int unsigned DvdW    = 97;
  localparam int unsigned DenW    = 65;
  localparam int unsigned BitCntW = $clog2(DvdW);

  typedef struct packed {
    logic [31:0] norm_x;
    logic [31:0] norm_y;
    logic [31:0] norm_z;
    logic [31:0] start_x;
    logic [31:0] start_y;
    logic [31:0] start_z;
    logic [31:0] end_x;
    logic [31:0] end_y;
    logic [31:0] end_z;
    logic [31:0] plane_offset;
  } lpi_in_t;

  typedef struct packed {
    logic [31:0] hit_x;
    logic [31:0] hit_y;
    logic [31:0] hit_z;
    logic        parallel;
  } lpi_out_t;

  // Classified query waiting for the divider.
  typedef struct packed {
    logic [2:0][31:0] start;
    logic [2:0][32:0] dmag;
    logic [2:0]       dneg;
    logic [63:0]      num_mag;
    logic             num_neg;
    logic [DenW-1:0]  den_mag;
    logic             den_neg;
    logic             par;
  } lpi_job_t;

  typedef struct packed {
    logic     valid;
    lpi_job_t job;
  } lpi_push_t;

  typedef struct packed {
    logic     empty;
    lpi_job_t head;
  } lpi_qstat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MLO,
    ST_MHI,
    ST_LOAD,
    ST_DIV,
    ST_FIN
  } lpi_state_e;

endpackage

// ===== sv/lpi_front.sv =====
// ----------------------------------------------------------------------------
// lpi_front
// Input register, direction and dot-product multipliers, then the sums that
// classify each query (parallel or not) and form the divider operands.
// ----------------------------------------------------------------------------
module lpi_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               acc_i,
  input  lpi_pkg::lpi_in_t   req_i,
  output lpi_pkg::lpi_push_t push_o
);

  logic             v0_q, v1_q;
  lpi_pkg::lpi_in_t in0_q;

  logic signed [2:0][31:0] n0, s0, e0;
  logic signed [2:0][31:0] s1_d, s1_q;
  logic signed [2:0][32:0] dir1_d, dir1_q;
  logic signed [2:0][63:0] ns_d, ns_q;
  logic signed [2:0][64:0] nd_d, nd_q;
  logic signed [31:0]      off1_q;

  always_comb begin
    n0 = {in0_q.norm_z, in0_q.norm_y, in0_q.norm_x};
    s0 = {in0_q.start_z, in0_q.start_y, in0_q.start_x};
    e0 = {in0_q.end_z, in0_q.end_y, in0_q.end_x};
    for (int k = 0; k < 3; k++) begin
      s1_d[k]   = s0[k];
      dir1_d[k] = 33'($signed(e0[k])) - 33'($signed(s0[k]));
      ns_d[k]   = 64'($signed(n0[k])) * 64'($signed(s0[k]));
      nd_d[k]   = 65'($signed(n0[k])) * 65'($signed(dir1_d[k]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else begin
      v0_q <= acc_i;
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      in0_q <= req_i;
    end
    if (v0_q) begin
      s1_q   <= s1_d;
      dir1_q <= dir1_d;
      ns_q   <= ns_d;
      nd_q   <= nd_d;
      off1_q <= $signed(in0_q.plane_offset);
    end
  end

  logic signed [65:0] sum_s, num_s, num_abs, den_s, den_abs;
  logic signed [33:0] dabs;

  always_comb begin
    sum_s = (66'($signed(off1_q)) <<< 16) + 66'($signed(ns_q[0]))
          + 66'($signed(ns_q[1])) + 66'($signed(ns_q[2]));
    num_s = -sum_s;
    num_abs = num_s[65] ? -num_s : num_s;
    den_s = 66'($signed(nd_q[0])) + 66'($signed(nd_q[1])) + 66'($signed(nd_q[2]));
    den_abs = den_s[65] ? -den_s : den_s;

    push_o.valid       = v1_q;
    push_o.job.num_mag = num_abs[63:0];
    push_o.job.num_neg = num_s[65];
    push_o.job.den_mag = den_abs[lpi_pkg::DenW-1:0];
    push_o.job.den_neg = den_s[65];
    push_o.job.par     = (den_s == '0);
    dabs = '0;
    for (int k = 0; k < 3; k++) begin
      dabs = dir1_q[k][32] ? -34'($signed(dir1_q[k])) : 34'($signed(dir1_q[k]));
      push_o.job.start[k] = s1_q[k];
      push_o.job.dmag[k]  = dabs[32:0];
      push_o.job.dneg[k]  = dir1_q[k][32];
    end
  end

endmodule

// ===== sv/lpi_queue.sv =====
// ----------------------------------------------------------------------------
// lpi_queue
// Short queue of classified queries between the front and the divider.
// ----------------------------------------------------------------------------
module lpi_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lpi_pkg::lpi_push_t  push_i,
  input  logic                pop_i,
  output lpi_pkg::lpi_qstat_t stat_o
);

  lpi_pkg::lpi_job_t             mem_q [lpi_pkg::QDepth];
  logic [lpi_pkg::QPtrW-1:0]     wr_q, rd_q;
  logic [lpi_pkg::QCntW-1:0]     cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i.valid) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      cnt_q <= cnt_q + lpi_pkg::QCntW'(push_i.valid) - lpi_pkg::QCntW'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem_q[wr_q] <= push_i.job;
    end
  end

  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.head  = mem_q[rd_q];

endmodule

// ===== sv/lpi_back.sv =====
// ----------------------------------------------------------------------------
// lpi_back
// Three-lane back end: split multiply of |dir| by |numerator|, restoring
// division one bit per cycle, rounding, and saturation of the hit point.
// ----------------------------------------------------------------------------
module lpi_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lpi_pkg::lpi_qstat_t stat_i,
  output logic                pop_o,
  output logic                valid_o,
  output lpi_pkg::lpi_out_t   res_o
);

  localparam int unsigned DvdW = lpi_pkg::DvdW;
  localparam int unsigned DenW = lpi_pkg::DenW;
  localparam logic [DvdW:0] QLim = (DvdW + 1)'(1) << 34;

  lpi_pkg::lpi_state_e state_q, state_d;
  lpi_pkg::lpi_job_t   job_q;
  logic [lpi_pkg::BitCntW-1:0] bit_q;
  logic [2:0][64:0]     plo_q, phi_q;
  logic [2:0][DvdW-1:0] dvd_q, quo_q;
  logic [2:0][DenW:0]   rem_q;
  logic                 valid_q;
  lpi_pkg::lpi_out_t    res_q;

  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    case (state_q)
      lpi_pkg::ST_IDLE: begin
        if (!stat_i.empty) begin
          pop_o   = 1'b1;
          state_d = stat_i.head.par ? lpi_pkg::ST_FIN : lpi_pkg::ST_MLO;
        end
      end
      lpi_pkg::ST_MLO:  state_d = lpi_pkg::ST_MHI;
      lpi_pkg::ST_MHI:  state_d = lpi_pkg::ST_LOAD;
      lpi_pkg::ST_LOAD: state_d = lpi_pkg::ST_DIV;
      lpi_pkg::ST_DIV: begin
        if (bit_q == '0) begin
          state_d = lpi_pkg::ST_FIN;
        end
      end
      lpi_pkg::ST_FIN:  state_d = lpi_pkg::ST_IDLE;
      default:          state_d = lpi_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lpi_pkg::ST_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= (state_q == lpi_pkg::ST_FIN);
    end
  end

  // Divider step and finishing logic for each lane.
  logic [2:0][DenW:0]   rsh, rem_nx;
  logic [2:0]           ge;
  logic [2:0]           rnd, tneg;
  logic [2:0][DvdW:0]   qr;
  logic signed [2:0][35:0] sm;
  logic [2:0][31:0]     hit;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rsh[k]    = {rem_q[k][DenW-1:0], dvd_q[k][DvdW-1]};
      ge[k]     = (rsh[k] >= {1'b0, job_q.den_mag});
      rem_nx[k] = ge[k] ? (rsh[k] - {1'b0, job_q.den_mag}) : rsh[k];

      rnd[k]  = ({rem_q[k][DenW-1:0], 1'b0} >= {1'b0, job_q.den_mag});
      qr[k]   = {1'b0, quo_q[k]} + (DvdW + 1)'(rnd[k]);
      tneg[k] = job_q.dneg[k] ^ job_q.num_neg ^ job_q.den_neg;
      sm[k]   = tneg[k] ? (36'($signed(job_q.start[k])) - $signed({1'b0, qr[k][34:0]}))
                        : (36'($signed(job_q.start[k])) + $signed({1'b0, qr[k][34:0]}));
      if (job_q.par) begin
        hit[k] = job_q.start[k];
      end else if (qr[k] > QLim) begin
        hit[k] = tneg[k] ? 32'h8000_0000 : 32'h7fff_ffff;
      end else if ($signed(sm[k]) > 36'sh0_7fff_ffff) begin
        hit[k] = 32'h7fff_ffff;
      end else if ($signed(sm[k]) < -36'sh0_8000_0000) begin
        hit[k] = 32'h8000_0000;
      end else begin
        hit[k] = sm[k][31:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      lpi_pkg::ST_IDLE: begin
        if (pop_o) begin
          job_q <= stat_i.head;
        end
      end
      lpi_pkg::ST_MLO: begin
        for (int k = 0; k < 3; k++) begin
          plo_q[k] <= 65'(job_q.dmag[k]) * 65'(job_q.num_mag[31:0]);
        end
      end
      lpi_pkg::ST_MHI: begin
        for (int k = 0; k < 3; k++) begin
          phi_q[k] <= 65'(job_q.dmag[k]) * 65'(job_q.num_mag[63:32]);
        end
      end
      lpi_pkg::ST_LOAD: begin
        bit_q <= lpi_pkg::BitCntW'(DvdW - 1);
        for (int k = 0; k < 3; k++) begin
          dvd_q[k] <= {phi_q[k][DvdW-33:0], 32'h0} + DvdW'(plo_q[k]);
          rem_q[k] <= '0;
          quo_q[k] <= '0;
        end
      end
      lpi_pkg::ST_DIV: begin
        bit_q <= bit_q - 1'b1;
        for (int k = 0; k < 3; k++) begin
          rem_q[k] <= rem_nx[k];
          quo_q[k] <= {quo_q[k][DvdW-2:0], ge[k]};
          dvd_q[k] <= {dvd_q[k][DvdW-2:0], 1'b0};
        end
      end
      lpi_pkg::ST_FIN: begin
        res_q.hit_x    <= hit[0];
        res_q.hit_y    <= hit[1];
        res_q.hit_z    <= hit[2];
        res_q.parallel <= job_q.par;
      end
      default: begin
      end
    endcase
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// ===== sv/line_plane_intersection.sv =====
// ----------------------------------------------------------------------------
// line_plane_intersection
// Intersection of a line segment with a plane, signed Q16.16 throughout.
// ----------------------------------------------------------------------------
// Usage: drive req_i and raise start; the request is taken at a rising edge
// with start high and busy low. One result comes back per request, in order,
// on res_o for exactly one cycle while res_valid_o is high. The receiver
// cannot stall; it must take each result in that cycle.
// The front (input register, multiplier stage, sums) always flows into a
// four-entry queue; busy rises when four requests are held in the front and
// the queue together. The back runs all three axes in parallel lanes: split
// 33x32 multiplies (low half, then high half), a load step, restoring
// division (one quotient bit per cycle), and a rounding/saturation step.
// The back holds one query at a time and pops the next only from idle; a
// parallel query skips the multiplies and the division and goes straight to
// the rounding/saturation step. Reset empties the front and the queue and
// drops any request in flight; no clearing pass is needed.
// ----------------------------------------------------------------------------
module line_plane_intersection (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  lpi_pkg::lpi_in_t  req_i,
  output logic              res_valid_o,
  output lpi_pkg::lpi_out_t res_o
);

  logic                       acc;
  logic                       pop;
  logic [lpi_pkg::QCntW-1:0]  cnt_q;
  lpi_pkg::lpi_push_t         push;
  lpi_pkg::lpi_qstat_t        qstat;

  assign busy = (cnt_q == lpi_pkg::QCntW'(lpi_pkg::QDepth));
  assign acc  = start && !busy;

  // Requests held anywhere ahead of the divider; bounds queue occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_q + lpi_pkg::QCntW'(acc) - lpi_pkg::QCntW'(pop);
    end
  end

  lpi_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .acc_i  (acc),
    .req_i  (req_i),
    .push_o (push)
  );

  lpi_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .stat_o (qstat)
  );

  lpi_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .stat_i  (qstat),
    .pop_o   (pop),
    .valid_o (res_valid_o),
    .res_o   (res_o)
  );

endmodule

// ===== sv/lpi_checker.sv =====
// ----------------------------------------------------------------------------
// lpi_checker
// Port-level checks for the line / plane intersection block.
// ----------------------------------------------------------------------------
module lpi_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              res_valid_o,
  input lpi_pkg::lpi_out_t res_o
);

  // The back end always returns to idle between results.
  a_no_back_to_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o)
    else $error("two results in consecutive cycles");

  // Occupancy only grows on an accepted request.
  a_busy_needs_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy && !start) |=> !busy)
    else $error("busy rose without a request");

  a_res_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !$isunknown(res_o.parallel))
    else $error("result flag unknown");

endmodule

bind line_plane_intersection lpi_checker u_lpi_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .res_valid_o (res_valid_o),
  .res_o       (res_o)
);
